[sv/lsi_pkg.sv]
// shared types and constants for the line segment intersection block
package lsi_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_MEET    = 2'd2
  } status_t;

  // classification that the front part hands to the back part
  typedef struct packed {
    logic parallel;
    logic meets;
  } cls_t;

  localparam int OUT_BITS  = 32;
  localparam int CLIP_EXP  = 40;   // quotients above 2**40 saturate outright
  localparam int QLOW_BITS = CLIP_EXP + 1;
  localparam int SUM_BITS  = QLOW_BITS + 2;
  localparam int TUSER_BITS = 8;

  localparam logic signed [OUT_BITS-1:0] INT32_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] INT32_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

[sv/lsi_front.sv]
// front part: direction vectors, determinant, numerators and classification
module lsi_front import lsi_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [8*COORD_BITS-1:0]     in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS-1:0]     out_a0x,
  output logic signed [COORD_BITS-1:0]     out_a0y,
  output logic signed [COORD_BITS:0]       out_ax,
  output logic signed [COORD_BITS:0]       out_ay,
  output logic signed [2*COORD_BITS+2:0]   out_d,
  output logic signed [2*COORD_BITS+2:0]   out_nt,
  output cls_t                        out_cls
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2*C + 2;
  localparam int NW = 2*C + 3;

  logic en;

  logic s1_valid, s2_valid, s3_valid, s4_valid;

  logic signed [C-1:0]  s1_a0x, s1_a0y;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_ox, s1_oy;

  logic signed [C-1:0]  s2_a0x, s2_a0y;
  logic signed [DW-1:0] s2_ax, s2_ay;
  logic signed [PW-1:0] s2_aybx, s2_axby, s2_byox, s2_bxoy, s2_ayox, s2_axoy;

  logic signed [C-1:0]  s3_a0x, s3_a0y;
  logic signed [DW-1:0] s3_ax, s3_ay;
  logic signed [NW-1:0] s3_d, s3_nt, s3_nu;

  logic signed [C-1:0]  s4_a0x, s4_a0y;
  logic signed [DW-1:0] s4_ax, s4_ay;
  logic signed [NW-1:0] s4_d, s4_nt;
  cls_t                 s4_cls;

  logic signed [C-1:0] f_a0x, f_a0y, f_a1x, f_a1y, f_b0x, f_b0y, f_b1x, f_b1y;

  // 0 <= n/d <= 1 for nonzero d
  function automatic logic in_unit(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] d);
    logic r;
    if (d > 0) begin
      r = (n >= 0) && (n <= d);
    end else begin
      r = (n <= 0) && (n >= d);
    end
    return r;
  endfunction

  assign en       = !(s4_valid && !out_ready);
  assign in_ready = en;

  assign f_a0x = in_data[0*C +: C];
  assign f_a0y = in_data[1*C +: C];
  assign f_a1x = in_data[2*C +: C];
  assign f_a1y = in_data[3*C +: C];
  assign f_b0x = in_data[4*C +: C];
  assign f_b0y = in_data[5*C +: C];
  assign f_b1x = in_data[6*C +: C];
  assign f_b1y = in_data[7*C +: C];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // differences
      s1_a0x <= f_a0x;
      s1_a0y <= f_a0y;
      s1_ax  <= $signed({f_a1x[C-1], f_a1x}) - $signed({f_a0x[C-1], f_a0x});
      s1_ay  <= $signed({f_a1y[C-1], f_a1y}) - $signed({f_a0y[C-1], f_a0y});
      s1_bx  <= $signed({f_b1x[C-1], f_b1x}) - $signed({f_b0x[C-1], f_b0x});
      s1_by  <= $signed({f_b1y[C-1], f_b1y}) - $signed({f_b0y[C-1], f_b0y});
      s1_ox  <= $signed({f_a0x[C-1], f_a0x}) - $signed({f_b0x[C-1], f_b0x});
      s1_oy  <= $signed({f_a0y[C-1], f_a0y}) - $signed({f_b0y[C-1], f_b0y});
      // cross products
      s2_a0x  <= s1_a0x;
      s2_a0y  <= s1_a0y;
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
      s2_aybx <= s1_ay * s1_bx;
      s2_axby <= s1_ax * s1_by;
      s2_byox <= s1_by * s1_ox;
      s2_bxoy <= s1_bx * s1_oy;
      s2_ayox <= s1_ay * s1_ox;
      s2_axoy <= s1_ax * s1_oy;
      // determinant and numerators
      s3_a0x <= s2_a0x;
      s3_a0y <= s2_a0y;
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_d   <= $signed({s2_aybx[PW-1], s2_aybx}) - $signed({s2_axby[PW-1], s2_axby});
      s3_nt  <= $signed({s2_byox[PW-1], s2_byox}) - $signed({s2_bxoy[PW-1], s2_bxoy});
      s3_nu  <= $signed({s2_ayox[PW-1], s2_ayox}) - $signed({s2_axoy[PW-1], s2_axoy});
      // classify
      s4_a0x <= s3_a0x;
      s4_a0y <= s3_a0y;
      s4_ax  <= s3_ax;
      s4_ay  <= s3_ay;
      s4_d   <= s3_d;
      s4_nt  <= s3_nt;
      s4_cls.parallel <= (s3_d == '0);
      s4_cls.meets    <= in_unit(s3_nt, s3_d) && in_unit(s3_nu, s3_d);
    end
  end

  assign out_valid = s4_valid;
  assign out_a0x   = s4_a0x;
  assign out_a0y   = s4_a0y;
  assign out_ax    = s4_ax;
  assign out_ay    = s4_ay;
  assign out_d     = s4_d;
  assign out_nt    = s4_nt;
  assign out_cls   = s4_cls;

endmodule

[sv/lsi_queue.sv]
// short register queue between the front and back parts
module lsi_queue import lsi_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/lsi_back.sv]
// back part: scaled direction, pipelined divide, offset add and saturation
module lsi_back import lsi_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    in_a0x,
  input  logic signed [COORD_BITS-1:0]    in_a0y,
  input  logic signed [COORD_BITS:0]      in_ax,
  input  logic signed [COORD_BITS:0]      in_ay,
  input  logic signed [2*COORD_BITS+2:0]  in_d,
  input  logic signed [2*COORD_BITS+2:0]  in_nt,
  input  cls_t                            in_cls,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OUT_BITS-1:0]             out_x,
  output logic [OUT_BITS-1:0]             out_y,
  output status_t                         out_status,
  output logic                            out_clipped
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int NW = 2*C + 3;
  localparam int PW = DW + NW;
  localparam int CW = (PW > QLOW_BITS) ? PW : QLOW_BITS;

  logic en;

  // magnitude stage
  logic            b0_valid;
  logic signed [C-1:0] b0_a0x, b0_a0y;
  logic [DW-1:0]   b0_mx, b0_my;
  logic [NW-1:0]   b0_nmag, b0_dmag;
  logic            b0_negx, b0_negy;
  cls_t            b0_cls;

  // divider stages, index 0 is the product stage
  logic              dv_valid [PW+1];
  logic signed [C-1:0] dv_a0x [PW+1];
  logic signed [C-1:0] dv_a0y [PW+1];
  logic [NW-1:0]     dv_dmag  [PW+1];
  logic              dv_negx  [PW+1];
  logic              dv_negy  [PW+1];
  cls_t              dv_cls   [PW+1];
  logic [PW-1:0]     dv_px    [PW+1];
  logic [PW-1:0]     dv_py    [PW+1];
  logic [NW-1:0]     dv_rx    [PW+1];
  logic [NW-1:0]     dv_ry    [PW+1];
  logic [PW-1:0]     dv_qx    [PW+1];
  logic [PW-1:0]     dv_qy    [PW+1];

  // sign and range stage
  logic                       f1_valid;
  logic signed [C-1:0]        f1_a0x, f1_a0y;
  logic signed [SUM_BITS-2:0] f1_qx, f1_qy;
  logic                       f1_clx, f1_cly;
  logic                       f1_negx, f1_negy;
  cls_t                       f1_cls;

  logic [CW-1:0]           qwx, qwy;
  logic signed [SUM_BITS-1:0] sx, sy;
  logic [OUT_BITS-1:0]     rx, ry;
  logic                    cx, cy;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
      f1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else if (en) begin
      b0_valid    <= in_valid;
      dv_valid[0] <= b0_valid;
      f1_valid    <= dv_valid[PW];
      out_valid   <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_a0x  <= in_a0x;
      b0_a0y  <= in_a0y;
      b0_mx   <= in_ax[DW-1] ? DW'(-in_ax) : DW'(in_ax);
      b0_my   <= in_ay[DW-1] ? DW'(-in_ay) : DW'(in_ay);
      b0_nmag <= in_nt[NW-1] ? NW'(-in_nt) : NW'(in_nt);
      b0_dmag <= in_d[NW-1]  ? NW'(-in_d)  : NW'(in_d);
      b0_negx <= in_ax[DW-1] ^ in_nt[NW-1] ^ in_d[NW-1];
      b0_negy <= in_ay[DW-1] ^ in_nt[NW-1] ^ in_d[NW-1];
      b0_cls  <= in_cls;

      dv_a0x[0]  <= b0_a0x;
      dv_a0y[0]  <= b0_a0y;
      dv_dmag[0] <= b0_dmag;
      dv_negx[0] <= b0_negx;
      dv_negy[0] <= b0_negy;
      dv_cls[0]  <= b0_cls;
      dv_px[0]   <= PW'(b0_mx) * PW'(b0_nmag);
      dv_py[0]   <= PW'(b0_my) * PW'(b0_nmag);
      dv_rx[0]   <= '0;
      dv_ry[0]   <= '0;
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < PW; k++) begin : g_div
    logic [NW:0] cand_x, cand_y;
    logic        ge_x, ge_y;

    assign cand_x = {dv_rx[k], dv_px[k][PW-1-k]};
    assign cand_y = {dv_ry[k], dv_py[k][PW-1-k]};
    assign ge_x   = cand_x >= {1'b0, dv_dmag[k]};
    assign ge_y   = cand_y >= {1'b0, dv_dmag[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_a0x[k+1]  <= dv_a0x[k];
        dv_a0y[k+1]  <= dv_a0y[k];
        dv_dmag[k+1] <= dv_dmag[k];
        dv_negx[k+1] <= dv_negx[k];
        dv_negy[k+1] <= dv_negy[k];
        dv_cls[k+1]  <= dv_cls[k];
        dv_px[k+1]   <= dv_px[k];
        dv_py[k+1]   <= dv_py[k];
        dv_rx[k+1]   <= ge_x ? NW'(cand_x - {1'b0, dv_dmag[k]}) : NW'(cand_x);
        dv_ry[k+1]   <= ge_y ? NW'(cand_y - {1'b0, dv_dmag[k]}) : NW'(cand_y);
        dv_qx[k+1]   <= {dv_qx[k][PW-2:0], ge_x};
        dv_qy[k+1]   <= {dv_qy[k][PW-2:0], ge_y};
      end
    end
  end

  assign qwx = CW'(dv_qx[PW]);
  assign qwy = CW'(dv_qy[PW]);

  always_ff @(posedge clk) begin
    if (en) begin
      f1_a0x  <= dv_a0x[PW];
      f1_a0y  <= dv_a0y[PW];
      f1_negx <= dv_negx[PW];
      f1_negy <= dv_negy[PW];
      f1_cls  <= dv_cls[PW];
      f1_clx  <= qwx > (CW'(1) << CLIP_EXP);
      f1_cly  <= qwy > (CW'(1) << CLIP_EXP);
      f1_qx   <= dv_negx[PW] ? -$signed({1'b0, qwx[QLOW_BITS-1:0]})
                             :  $signed({1'b0, qwx[QLOW_BITS-1:0]});
      f1_qy   <= dv_negy[PW] ? -$signed({1'b0, qwy[QLOW_BITS-1:0]})
                             :  $signed({1'b0, qwy[QLOW_BITS-1:0]});
    end
  end

  assign sx = SUM_BITS'(f1_a0x) + SUM_BITS'(f1_qx);
  assign sy = SUM_BITS'(f1_a0y) + SUM_BITS'(f1_qy);

  always_comb begin
    cx = 1'b1;
    cy = 1'b1;
    if (f1_clx) begin
      rx = f1_negx ? INT32_MIN : INT32_MAX;
    end else if (sx > SUM_BITS'(INT32_MAX)) begin
      rx = INT32_MAX;
    end else if (sx < SUM_BITS'(INT32_MIN)) begin
      rx = INT32_MIN;
    end else begin
      rx = sx[OUT_BITS-1:0];
      cx = 1'b0;
    end
    if (f1_cly) begin
      ry = f1_negy ? INT32_MIN : INT32_MAX;
    end else if (sy > SUM_BITS'(INT32_MAX)) begin
      ry = INT32_MAX;
    end else if (sy < SUM_BITS'(INT32_MIN)) begin
      ry = INT32_MIN;
    end else begin
      ry = sy[OUT_BITS-1:0];
      cy = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f1_cls.parallel) begin
        out_x       <= '0;
        out_y       <= '0;
        out_status  <= ST_NONE;
        out_clipped <= 1'b0;
      end else begin
        out_x       <= rx;
        out_y       <= ry;
        out_status  <= f1_cls.meets ? ST_MEET : ST_OUTSIDE;
        out_clipped <= cx || cy;
      end
    end
  end

endmodule

[sv/line_segment_intersect.sv]
// top level of the line segment intersection block
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: eight endpoint coordinates
//  m_       out  m_tvalid/m_tready  m_tdata: cross point, m_tuser: status, clipped
//
// one word enters per cycle when nothing stalls; one result word per input word
// a word passes the front pipeline, the queue and the back pipeline in turn; the back
// pipeline length is set by the bit-per-stage divider (one stage per quotient bit)
// synchronous active-high reset clears all valid bits and the queue
// a stalled output freezes the back pipeline; the front keeps filling the
// queue and drops s_tready only once the queue is full
module line_segment_intersect import lsi_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // cross_x, cross_y
  output logic [2*OUT_BITS-1:0]     m_tdata,
  // status [1:0], clipped [2], zeros above
  output logic [TUSER_BITS-1:0]     m_tuser
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int NW = 2*C + 3;
  localparam int QW = 2*C + 2*DW + 2*NW + $bits(cls_t);

  // front to queue
  logic                 f_valid, f_ready;
  logic signed [C-1:0]  f_a0x, f_a0y;
  logic signed [DW-1:0] f_ax, f_ay;
  logic signed [NW-1:0] f_d, f_nt;
  cls_t                 f_cls;

  // queue to back
  logic                 q_valid, q_ready;
  logic [QW-1:0]        q_data;
  logic signed [C-1:0]  q_a0x, q_a0y;
  logic signed [DW-1:0] q_ax, q_ay;
  logic signed [NW-1:0] q_d, q_nt;
  cls_t                 q_cls;

  logic [OUT_BITS-1:0]  cross_x, cross_y;
  status_t              status;
  logic                 clipped;

  lsi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_a0x   (f_a0x),
    .out_a0y   (f_a0y),
    .out_ax    (f_ax),
    .out_ay    (f_ay),
    .out_d     (f_d),
    .out_nt    (f_nt),
    .out_cls   (f_cls)
  );

  lsi_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cls, f_nt, f_d, f_ay, f_ax, f_a0y, f_a0x}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign {q_cls, q_nt, q_d, q_ay, q_ax, q_a0y, q_a0x} = q_data;

  lsi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_a0x      (q_a0x),
    .in_a0y      (q_a0y),
    .in_ax       (q_ax),
    .in_ay       (q_ay),
    .in_d        (q_d),
    .in_nt       (q_nt),
    .in_cls      (q_cls),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_x       (cross_x),
    .out_y       (cross_y),
    .out_status  (status),
    .out_clipped (clipped)
  );

  assign m_tdata = {cross_y, cross_x};
  assign m_tuser = {{(TUSER_BITS-3){1'b0}}, clipped, status};

endmodule

[sv/lsi_checker.sv]
// port-level checks on the result channel, bound to the top level
module lsi_checker import lsi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [2*OUT_BITS-1:0] m_tdata,
  input logic [TUSER_BITS-1:0] m_tuser
);

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // a waiting word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  // status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != 2'd3)
    else $error("unused status code");

  // parallel case carries a zero point and no clip
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ST_NONE |-> m_tdata == '0 && !m_tuser[2])
    else $error("nonzero payload with status none");

  // a clipped point has a coordinate at a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |->
      m_tdata[OUT_BITS-1:0] == INT32_MAX || m_tdata[OUT_BITS-1:0] == INT32_MIN ||
      m_tdata[2*OUT_BITS-1:OUT_BITS] == INT32_MAX ||
      m_tdata[2*OUT_BITS-1:OUT_BITS] == INT32_MIN)
    else $error("clipped set without a saturated coordinate");

endmodule

bind line_segment_intersect lsi_checker u_lsi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
